FILE: design/vfst_pkg.sv
package vfst_pkg;

    typedef enum logic [3:0] {
        PH_VS_START = 4'b0001,
        PH_VS_END   = 4'b0010,
        PH_FR_START = 4'b0100,
        PH_FRAME    = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_VSYNC  = 2'd1,
        CMD_VBLANK = 2'd2
    } cmd_t;

    localparam logic [1:0] CFG_FRAME_LINES    = 2'd0;
    localparam logic [1:0] CFG_START_LINE     = 2'd1;
    localparam logic [1:0] CFG_VISIBLE_HEIGHT = 2'd2;

    localparam logic [9:0] FRAME_LINES_RST    = 10'd262;
    localparam logic [9:0] START_LINE_RST     = 10'd23;
    localparam logic [9:0] VISIBLE_HEIGHT_RST = 10'd228;

    localparam logic [1:0] CODE_VS_START = 2'd0;
    localparam logic [1:0] CODE_VS_END   = 2'd1;
    localparam logic [1:0] CODE_FR_START = 2'd2;
    localparam logic [1:0] CODE_FRAME    = 2'd3;

    typedef struct packed {
        phase_t      phase;
        logic [9:0]  lines_in_phase;
        logic [6:0]  bailout_count;
        logic [9:0]  row_in_frame;
        logic [10:0] last_row;
        logic        pulse_pending;
        logic [1:0]  pending_lines;
        logic [3:0]  frames_seen;
        logic [9:0]  frame_line_total;
        logic        vsync_level;
        logic        vblank_level;
    } vfst_state_t;

    typedef struct packed {
        logic [1:0]  sync_state;
        logic        rendering;
        logic        frame_done;
        logic [9:0]  visible_line;
        logic [10:0] last_drawn_line;
    } vfst_result_t;

    typedef struct packed {
        logic [9:0] frame_lines;
        logic [9:0] start_line;
        logic [9:0] visible_height;
    } vfst_cfg_t;

    function automatic logic [1:0] phase_code(input phase_t p);
        logic [1:0] c;
        case (p)
            PH_VS_START: c = CODE_VS_START;
            PH_VS_END:   c = CODE_VS_END;
            PH_FR_START: c = CODE_FR_START;
            PH_FRAME:    c = CODE_FRAME;
            default:     c = CODE_VS_START;
        endcase
        return c;
    endfunction

endpackage

FILE: design/vfst_step.sv
module vfst_step import vfst_pkg::*; #(
    parameter int VSYNC_LINE_LIMIT = 50,
    parameter int LONG_FRAME_LINES = 312
) (
    input  vfst_state_t  state,
    input  vfst_cfg_t    cfg,
    input  logic [1:0]   command,
    input  logic         level,
    output vfst_state_t  state_next,
    output vfst_result_t result
);

    localparam logic [6:0]  BAIL_LIMIT = 7'(VSYNC_LINE_LIMIT);
    localparam logic [10:0] LONG_TOTAL = 11'(2 * LONG_FRAME_LINES);

    // phase entry side effects; a no-op when already in the target phase
    function automatic vfst_state_t enter_phase(input vfst_state_t s, input phase_t p);
        vfst_state_t r;
        r = s;
        if (s.phase != p) begin
            r.phase = p;
            r.lines_in_phase = '0;
            if (p == PH_FR_START) begin
                r.frames_seen = (s.frames_seen == '1) ? s.frames_seen : s.frames_seen + 4'd1;
                r.frame_line_total = '0;
                r.bailout_count = '0;
            end else if (p == PH_FRAME) begin
                r.bailout_count = '0;
                r.row_in_frame = '0;
            end
        end
        return r;
    endfunction

    vfst_state_t s;
    logic        done;
    logic        bail_en;
    phase_t      prev;

    always_comb begin
        s = state;
        done = 1'b0;
        bail_en = 1'b0;
        prev = state.phase;
        case (cmd_t'(command))
            CMD_TICK: begin
                if (s.frame_line_total != '1) s.frame_line_total = s.frame_line_total + 10'd1;
                if (s.lines_in_phase != '1) s.lines_in_phase = s.lines_in_phase + 10'd1;
                if (s.pulse_pending) begin
                    if (s.pending_lines != '1) s.pending_lines = s.pending_lines + 2'd1;
                    if (s.pending_lines >= 2'd2) begin
                        s.pulse_pending = 1'b0;
                        s = enter_phase(s, PH_VS_END);
                    end
                end
                bail_en = s.vblank_level || ({1'b0, s.frame_line_total} > LONG_TOTAL);
                case (s.phase)
                    PH_VS_START, PH_VS_END: begin
                        // in wait-for-start, bail-out only counts near the end of a frame or before any frame was seen
                        if (s.phase == PH_VS_END
                            || ({1'b0, s.frame_line_total} + 11'd3 > {1'b0, cfg.frame_lines})
                            || s.frames_seen == '0) begin
                            if (bail_en && s.bailout_count != '1)
                                s.bailout_count = s.bailout_count + 7'd1;
                        end
                        if (s.bailout_count > BAIL_LIMIT) begin
                            s = enter_phase(s, PH_FR_START);
                            done = 1'b1;
                        end
                    end
                    PH_FR_START: begin
                        if (s.lines_in_phase >= cfg.start_line) s = enter_phase(s, PH_FRAME);
                    end
                    default: begin
                        if (s.lines_in_phase >= cfg.visible_height) begin
                            s.last_row = {1'b0, cfg.start_line} + {1'b0, s.row_in_frame};
                            s = enter_phase(s, PH_VS_START);
                        end
                    end
                endcase
                if (s.phase == PH_FRAME && prev == PH_FRAME && s.row_in_frame != '1)
                    s.row_in_frame = s.row_in_frame + 10'd1;
            end
            CMD_VSYNC: begin
                if (level != s.vsync_level) begin
                    s.vsync_level = level;
                    if (level) begin
                        if (!(s.phase == PH_VS_END || s.pulse_pending)) begin
                            s.pulse_pending = 1'b1;
                            s.pending_lines = '0;
                        end
                    end else begin
                        s.pulse_pending = 1'b0;
                        if (s.phase == PH_VS_END) begin
                            s = enter_phase(s, PH_FR_START);
                            done = 1'b1;
                        end
                    end
                end
            end
            CMD_VBLANK: begin
                s.vblank_level = level;
            end
            default: begin
            end
        endcase
    end

    assign state_next             = s;
    assign result.sync_state      = phase_code(s.phase);
    assign result.rendering       = (s.phase == PH_FRAME);
    assign result.frame_done      = done;
    assign result.visible_line    = s.row_in_frame;
    assign result.last_drawn_line = s.last_row;

endmodule

FILE: design/video_frame_sync_tracker.sv
// Vertical frame timing tracker.
// Input channel (s_*): one request per event; s_command selects a scanline
// tick, a VSYNC level change or a VBLANK level change, s_level carries the
// new level. Command 3 leaves the state as is and still yields a result.
// Result channel (m_*): exactly one result per request: phase code, rendering
// flag, frame-done pulse, visible line and last drawn line.
// From acceptance to m_valid a request passes the input register and then
// the result register; the phase update is the only logic between the two.
// One request per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result register holds; an empty input register
// still takes one more request, then s_ready drops until m_ready returns.
// Config writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at the next
// edge and are meant for idle periods only; indexes beyond the register list
// are ignored.
// Reset (aresetn low, synchronous) empties both registers, restores the
// configuration defaults and returns to waiting for VSYNC start.
module video_frame_sync_tracker import vfst_pkg::*; #(
    parameter int VSYNC_LINE_LIMIT = 50,
    parameter int LONG_FRAME_LINES = 312
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic        s_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_sync_state,
    output logic        m_rendering,
    output logic        m_frame_done,
    output logic [9:0]  m_visible_line,
    output logic [10:0] m_last_drawn_line
);

    vfst_cfg_t    cfg_reg;
    vfst_state_t  st_reg;
    vfst_state_t  st_next;
    vfst_result_t res_next;
    vfst_result_t out_reg;
    logic         out_valid_reg;
    logic         in_valid_reg;
    logic [1:0]   in_cmd_reg;
    logic         in_level_reg;
    logic         advance;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_lines    <= FRAME_LINES_RST;
            cfg_reg.start_line     <= START_LINE_RST;
            cfg_reg.visible_height <= VISIBLE_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_LINES:    cfg_reg.frame_lines    <= cfg_wdata;
                CFG_START_LINE:     cfg_reg.start_line     <= cfg_wdata;
                CFG_VISIBLE_HEIGHT: cfg_reg.visible_height <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg   <= s_command;
            in_level_reg <= s_level;
        end
    end

    vfst_step #(
        .VSYNC_LINE_LIMIT(VSYNC_LINE_LIMIT),
        .LONG_FRAME_LINES(LONG_FRAME_LINES)
    ) u_step (
        .state      (st_reg),
        .cfg        (cfg_reg),
        .command    (in_cmd_reg),
        .level      (in_level_reg),
        .state_next (st_next),
        .result     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{phase: PH_VS_START, default: '0};
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_reg <= res_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_sync_state      = out_reg.sync_state;
    assign m_rendering       = out_reg.rendering;
    assign m_frame_done      = out_reg.frame_done;
    assign m_visible_line    = out_reg.visible_line;
    assign m_last_drawn_line = out_reg.last_drawn_line;

endmodule
